FILE: rtl/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and the CRC-16 byte update for the command frame
// builder.
// ----------------------------------------------------------------------------
`default_nettype none

package cfb_pkg;

  // Frame layout
  localparam int unsigned FrameLen = 12;
  localparam int unsigned CrcSpan  = 10;
  localparam int unsigned IdxW     = $clog2(FrameLen);

  localparam logic [IdxW-1:0] PosStart = IdxW'(0);
  localparam logic [IdxW-1:0] PosMode  = IdxW'(1);
  localparam logic [IdxW-1:0] PosValA  = IdxW'(2);
  localparam logic [IdxW-1:0] PosValB  = IdxW'(6);
  localparam logic [IdxW-1:0] PosCrcLo = IdxW'(CrcSpan);
  localparam logic [IdxW-1:0] PosCrcHi = IdxW'(CrcSpan + 1);
  localparam logic [IdxW-1:0] PosLast  = IdxW'(FrameLen - 1);

  localparam logic [7:0]  StartByte = 8'hAA;
  localparam logic [7:0]  DedupMode = 8'd2;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;

  // One command
  typedef struct packed {
    logic [7:0]  mode;
    logic [31:0] value_a;
    logic [31:0] value_b;
  } cmd_t;

  // One frame byte
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } result_t;

  // Modbus CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cfb_dedup.sv
// ----------------------------------------------------------------------------
// cfb_dedup
// Input register with duplicate suppression: drops a mode 2 command equal to
// the last command passed on, and holds the rest for the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_dedup (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire cfb_pkg::cmd_t in_data_i,
  output logic              cmd_valid_o,
  input  wire logic         cmd_ready_i,
  output cfb_pkg::cmd_t     cmd_data_o
);
  import cfb_pkg::*;

  logic hold_valid_q, hold_valid_d;
  cmd_t hold_q;
  cmd_t prev_q;
  logic have_prev_q;
  logic accept;
  logic dup;

  // Accept when the holding register is empty or drains this cycle
  assign in_ready_o = !hold_valid_q || cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Flag a repeat of the previous sent command in mode 2
  assign dup = have_prev_q && (in_data_i.mode == DedupMode) && (in_data_i == prev_q);

  // Update holding register occupancy
  always_comb begin
    hold_valid_d = hold_valid_q;
    if (hold_valid_q && cmd_ready_i) begin
      hold_valid_d = 1'b0;
    end
    if (accept && !dup) begin
      hold_valid_d = 1'b1;
    end
  end

  // Track occupancy and the previous command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      have_prev_q  <= 1'b0;
      prev_q       <= '0;
    end else begin
      hold_valid_q <= hold_valid_d;
      if (accept && !dup) begin
        have_prev_q <= 1'b1;
        prev_q      <= in_data_i;
      end
    end
  end

  // Capture the command payload
  always_ff @(posedge clk_i) begin
    if (accept && !dup) begin
      hold_q <= in_data_i;
    end
  end

  assign cmd_valid_o = hold_valid_q;
  assign cmd_data_o  = hold_q;

endmodule

`default_nettype wire

FILE: rtl/cfb_serializer.sv
// ----------------------------------------------------------------------------
// cfb_serializer
// Emits the 12-byte frame of one command, one byte per transfer, updating
// the CRC-16 as each covered byte leaves, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_serializer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire cfb_pkg::cmd_t cmd_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output cfb_pkg::result_t   out_data_o
);
  import cfb_pkg::*;

  logic            busy_q;
  logic [IdxW-1:0] idx_q;
  cmd_t            cmd_q;
  logic [15:0]     crc_q;
  logic            out_valid_q;
  result_t         out_q;
  logic            advance;
  logic            at_last;
  logic            load;
  logic [7:0]      cur_byte;

  // While busy, step one byte whenever the output register is free or drains
  assign advance     = busy_q && (!out_valid_q || out_ready_i);
  assign at_last     = (idx_q == PosLast);
  assign cmd_ready_o = !busy_q || (advance && at_last);
  assign load        = cmd_valid_i && cmd_ready_o;

  // Select the current frame byte
  always_comb begin
    case (idx_q) inside
      PosStart:                      cur_byte = StartByte;
      PosMode:                       cur_byte = cmd_q.mode;
      [PosValA:PosValA+IdxW'(3)]:    cur_byte = cmd_q.value_a[8*(idx_q-PosValA) +: 8];
      [PosValB:PosValB+IdxW'(3)]:    cur_byte = cmd_q.value_b[8*(idx_q-PosValB) +: 8];
      PosCrcLo:                      cur_byte = crc_q[7:0];
      PosCrcHi:                      cur_byte = crc_q[15:8];
      default:                       cur_byte = 8'h00;
    endcase
  end

  // Control: busy flag, byte index, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (advance) begin
        idx_q <= idx_q + IdxW'(1);
        if (at_last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: command, running CRC, output byte
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.frame_byte <= cur_byte;
      out_q.last_byte  <= at_last;
      if (idx_q < PosCrcLo) begin
        crc_q <= crc_byte(crc_q, cur_byte);
      end
    end
    if (load) begin
      cmd_q <= cmd_data_i;
      crc_q <= CrcInit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/command_frame_builder_crc16.sv
// ----------------------------------------------------------------------------
// command_frame_builder_crc16
// Builds a 12-byte serial frame (start, mode, two little-endian words,
// Modbus CRC-16) for each command, suppressing repeated mode 2 commands.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload                      Dir
//  in        in_valid_i/in_ready_o  in_data_i  (mode, value_a/b)  in
//  out       out_valid_o/out_ready_i out_data_o (frame_byte,last) out
//
//  A sent command yields 12 byte transfers, one per cycle while out_ready_i
//  holds high; the byte serializer sets the command rate.
//  The first byte goes through the input, command and output registers.
//  A suppressed duplicate is dropped at the input with no output.
//  One command waits in the input register while a frame is emitted.
//  Reset clears the previous-command memory; the first command is sent.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_builder_crc16 (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire cfb_pkg::cmd_t    in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output cfb_pkg::result_t      out_data_o
);
  import cfb_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd_data;

  // Filter duplicates and hold the next command
  cfb_dedup u_dedup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_data_o  (cmd_data)
  );

  // Emit frame bytes with the CRC
  cfb_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_data_i  (cmd_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: tb/command_frame_builder_crc16_test.sv
// ----------------------------------------------------------------------------
// command_frame_builder_crc16_test
// Drives commands into the frame builder and checks every emitted frame byte
// against a predicted 12-byte frame (start, mode, both words little-endian,
// Modbus CRC-16). Covers duplicate suppression in mode 2 and runs through
// phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module command_frame_builder_crc16_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cfb_pkg::*;

  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned DrainCycles    = 40;
  localparam int unsigned RandomCommands = 308;

  // Predicts frames from accepted commands and holds the bytes still owed
  class frame_scoreboard;
    cmd_t      last_cmd;
    bit        have_last;
    result_t   expected_bytes[$];
    int        errors;

    function new();
      last_cmd    = '0;
      have_last   = 1'b0;
      errors      = 0;
    endfunction

    // Reflected polynomial, one bit per step, LSB first
    function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      int          k;
      c = crc ^ {8'h00, b};
      for (k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
    endfunction

    // Build the expected frame for one accepted command
    function void note_command(cmd_t c);
      logic [7:0]  frame [FrameLen];
      logic [15:0] crc;
      result_t     r;
      int          i;
      // Drop a repeated mode 2 command
      if (have_last && c.mode == DedupMode && c == last_cmd) begin
        return;
      end
      last_cmd  = c;
      have_last = 1'b1;
      frame[0] = StartByte;
      frame[1] = c.mode;
      for (i = 0; i < 4; i++) begin
        frame[2 + i] = c.value_a[8*i +: 8];
        frame[6 + i] = c.value_b[8*i +: 8];
      end
      crc = CrcInit;
      for (i = 0; i < CrcSpan; i++) begin
        crc = crc16_step(crc, frame[i]);
      end
      frame[CrcSpan]     = crc[7:0];
      frame[CrcSpan + 1] = crc[15:8];
      for (i = 0; i < FrameLen; i++) begin
        r.frame_byte = frame[i];
        r.last_byte  = (i == FrameLen - 1);
        expected_bytes.push_back(r);
      end
    endfunction

    // Compare one output transfer with the oldest expected byte
    function void check_byte(result_t got);
      result_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected frame byte %02h (last_byte %0b)", got.frame_byte, got.last_byte);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.frame_byte !== want.frame_byte) begin
        $error("frame_byte mismatch: expected %02h, actual %02h",
               want.frame_byte, got.frame_byte);
        errors++;
      end
      if (got.last_byte !== want.last_byte) begin
        $error("last_byte mismatch: expected %0b, actual %0b", want.last_byte, got.last_byte);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    in_ready_o;
  cmd_t    in_data_i   = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  result_t out_data_o;

  frame_scoreboard scoreboard;
  int  sender_idle_pct    = 0;
  int  receiver_stall_pct = 0;
  int  quiet_cycles       = 0;
  cmd_t last_sent;

  command_frame_builder_crc16 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Stall the output side at the phase rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Sample transfers on both channels; watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        scoreboard.note_command(in_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        scoreboard.check_byte(out_data_o);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Offer one command, idling first at the phase rate, and hold until transfer
  task automatic send_command(cmd_t c);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    last_sent  = c;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7FC0_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h7F80_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly mode 2 traffic with repeats, so suppression gets exercised
  function automatic cmd_t pick_command(cmd_t prev);
    cmd_t c;
    int   r;
    r = $urandom_range(99);
    c.value_a = pick_word();
    c.value_b = pick_word();
    if (r < 25) begin
      c = prev;
    end else if (r < 35) begin
      c = prev;
      c.mode = DedupMode;
    end else if (r < 45) begin
      c = prev;
      if ($urandom_range(1)) c.value_a = pick_word();
      else c.value_b = pick_word();
    end else if (r < 65) begin
      c.mode = DedupMode;
    end else begin
      c.mode = 8'($urandom_range(255));
    end
    return c;
  endfunction

  initial begin
    int sent;
    int phase;
    scoreboard = new();
    last_sent  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first command after reset has the zero values of the cleared memory
    send_command(cmd_t'{DedupMode, 32'h0000_0000, 32'h0000_0000});
    send_command(cmd_t'{DedupMode, 32'h0000_0000, 32'h0000_0000});
    send_command(cmd_t'{8'd0, 32'h0000_0000, 32'h0000_0000});
    send_command(cmd_t'{8'd0, 32'h0000_0000, 32'h0000_0000});
    // Signed zeros differ bitwise
    send_command(cmd_t'{DedupMode, 32'h0000_0000, 32'h0000_0000});
    send_command(cmd_t'{DedupMode, 32'h8000_0000, 32'h0000_0000});
    send_command(cmd_t'{DedupMode, 32'h8000_0000, 32'h0000_0000});
    send_command(cmd_t'{DedupMode, 32'h8000_0000, 32'h8000_0000});
    // Equal NaN patterns match
    send_command(cmd_t'{DedupMode, 32'h7FC0_0000, 32'h7FC0_0001});
    send_command(cmd_t'{DedupMode, 32'h7FC0_0000, 32'h7FC0_0001});
    send_command(cmd_t'{DedupMode, 32'h7FC0_0000, 32'h7FC0_0000});
    // Same values under another mode, then back to mode 2
    send_command(cmd_t'{8'd3, 32'h7FC0_0000, 32'h7FC0_0000});
    send_command(cmd_t'{DedupMode, 32'h7FC0_0000, 32'h7FC0_0000});
    send_command(cmd_t'{DedupMode, 32'h7FC0_0000, 32'h7FC0_0000});
    // Field extremes
    send_command(cmd_t'{8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_command(cmd_t'{8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_command(cmd_t'{8'h00, 32'hFFFF_FFFF, 32'h0000_0000});
    send_command(cmd_t'{8'hAA, 32'h3F80_0000, 32'hBF80_0000});
    send_command(cmd_t'{8'h01, 32'h1234_5678, 32'h89AB_CDEF});
    send_command(cmd_t'{DedupMode, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_command(cmd_t'{DedupMode, 32'hFFFF_FFFF, 32'hFFFF_FFFE});
    send_command(cmd_t'{DedupMode, 32'hFFFF_FFFF, 32'hFFFF_FFFE});

    // Random phases: none, sender idle, receiver stall, both
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
        default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase
      for (sent = 0; sent < RandomCommands / 4; sent++) begin
        send_command(pick_command(last_sent));
      end
    end
    in_valid_i <= 1'b0;

    // Drain, then give stray bytes time to show up
    while (scoreboard.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/cfb_pkg.sv
rtl/cfb_dedup.sv
rtl/cfb_serializer.sv
rtl/command_frame_builder_crc16.sv
tb/command_frame_builder_crc16_test.sv
